[src/irpd_pkg.sv]
// ----------------------------------------------------------------------------
// IR remote pulse decoder package
// Types, register indexes, phase codes and frame codes used by the decoder;
// its word types are carried on the stream interface.
// ----------------------------------------------------------------------------
`default_nettype none

package irpd_pkg;

    // Widths of the fields carried on the channels and of the bit counter.
    localparam int unsigned DUR_W   = 16;
    localparam int unsigned KEY_W   = 3;
    localparam int unsigned CODE_W  = 8;
    localparam int unsigned COUNT_W = 5;

    // Number of data bits in one frame, and the bit at which byte one ends.
    localparam logic [COUNT_W-1:0] FRAME_BITS    = 5'd24;
    localparam logic [COUNT_W-1:0] BYTE_ONE_BITS = 5'd16;

    // Reset values of the timing registers, in microseconds.
    localparam logic [DUR_W-1:0] HEADER_MIN_RST = 16'd3700;
    localparam logic [DUR_W-1:0] HEADER_MAX_RST = 16'd4200;
    localparam logic [DUR_W-1:0] ZERO_MIN_RST   = 16'd900;
    localparam logic [DUR_W-1:0] ZERO_MAX_RST   = 16'd1200;

    // Frame codes that act on the flags and the key store.
    localparam logic [CODE_W-1:0] CODE_STOP  = 8'd176;
    localparam logic [CODE_W-1:0] CODE_DEBUG = 8'd81;
    localparam logic [CODE_W-1:0] CODE_UP    = 8'd110;
    localparam logic [CODE_W-1:0] CODE_OK    = 8'd210;
    localparam logic [CODE_W-1:0] CODE_LEFT  = 8'd155;
    localparam logic [CODE_W-1:0] CODE_RIGHT = 8'd35;
    localparam logic [CODE_W-1:0] CODE_DOWN  = 8'd230;

    // Key values held in the key store.
    localparam logic [KEY_W-1:0] KEY_NONE  = 3'd0;
    localparam logic [KEY_W-1:0] KEY_UP    = 3'd1;
    localparam logic [KEY_W-1:0] KEY_OK    = 3'd2;
    localparam logic [KEY_W-1:0] KEY_LEFT  = 3'd3;
    localparam logic [KEY_W-1:0] KEY_RIGHT = 3'd4;
    localparam logic [KEY_W-1:0] KEY_DOWN  = 3'd5;

    // Input word commands.
    localparam logic CMD_PULSE = 1'b0;
    localparam logic CMD_KEY   = 1'b1;

    // Line levels.
    localparam logic LEVEL_LOW  = 1'b0;
    localparam logic LEVEL_HIGH = 1'b1;

    // Decoder phase.
    typedef enum logic [1:0] {
        PH_HDR_LOW  = 2'd0,
        PH_HDR_HIGH = 2'd1,
        PH_DAT_LOW  = 2'd2,
        PH_DAT_HIGH = 2'd3
    } t_phase;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_HEADER_MIN = 2'd0,
        REG_HEADER_MAX = 2'd1,
        REG_ZERO_MIN   = 2'd2,
        REG_ZERO_MAX   = 2'd3
    } t_reg_idx;

    // One measured pulse or key overwrite.
    typedef struct packed {
        logic             command;
        logic             pulse_level;
        logic [DUR_W-1:0] pulse_us;
        logic [KEY_W-1:0] key_in;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [KEY_W-1:0]  key_value;
        logic              stop_out;
        logic              debug_out;
        logic              code_valid;
        logic [CODE_W-1:0] frame_code;
    } t_out_word;

    // One configuration write.
    typedef struct packed {
        t_reg_idx         index;
        logic [DUR_W-1:0] data;
    } t_cfg_word;

endpackage : irpd_pkg

`default_nettype wire

[src/irpd_stream_if.sv]
// ----------------------------------------------------------------------------
// IR remote pulse decoder stream interface
// A valid/ready channel that moves one word of a given type per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface irpd_stream_if #(
    parameter type T_WORD = logic
) ();

    logic  valid;
    logic  ready;
    T_WORD payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface : irpd_stream_if

`default_nettype wire

[src/ir_remote_pulse_decoder.sv]
// Flow: an accepted word is held in the input register, and its result word is
// loaded into the output register once the output side is free; the sink takes
// it from there.
// Throughput: one word per cycle unless the output side stalls; the input and
// output registers form a two-stage pipeline that advances when the output is free.
// Reset (synchronous, active low) returns the decoder to the header-low phase,
// clears the counters, key store and flags, and loads the default timings.
// ----------------------------------------------------------------------------
// IR remote pulse decoder
// Decodes pulse-distance IR remote frames from measured pulses and drives a
// key value, a stop flag and a debug flag from the frame code.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_remote_pulse_decoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    irpd_stream_if.sink   i_in,
    irpd_stream_if.source o_out,
    irpd_stream_if.sink   i_cfg
);

    import irpd_pkg::*;

    // Configuration registers.
    logic [DUR_W-1:0] r_header_min;
    logic [DUR_W-1:0] r_header_max;
    logic [DUR_W-1:0] r_zero_min;
    logic [DUR_W-1:0] r_zero_max;

    // Pipeline registers.
    logic      r_s1_valid;
    t_in_word  r_s1_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    // Decoder state.
    t_phase             r_phase;
    t_phase             n_phase;
    logic [COUNT_W-1:0] r_bit_count;
    logic [COUNT_W-1:0] n_bit_count;
    logic [CODE_W-1:0]  r_shift_byte;
    logic [CODE_W-1:0]  n_shift_byte;
    logic [CODE_W-1:0]  r_code_sum;
    logic [CODE_W-1:0]  n_code_sum;
    logic [KEY_W-1:0]   r_key_store;
    logic [KEY_W-1:0]   n_key_store;
    logic               r_stop_flag;
    logic               n_stop_flag;
    logic               r_debug_flag;
    logic               n_debug_flag;
    t_out_word          n_out_word;

    // Handshake and decode terms.
    logic               out_free;
    logic               s1_fire;
    logic               header_ok;
    logic               zero_bit;
    logic [COUNT_W-1:0] count_inc;
    logic [CODE_W-1:0]  shifted;
    logic               frame_done;
    logic [CODE_W-1:0]  code_sum_total;

    // The input register moves on whenever the output register is empty or
    // its word is being taken in this cycle.
    assign out_free    = !r_out_valid || o_out.ready;
    assign s1_fire     = r_s1_valid && out_free;
    assign i_in.ready  = !r_s1_valid || out_free;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_word;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_min <= HEADER_MIN_RST;
            r_header_max <= HEADER_MAX_RST;
            r_zero_min   <= ZERO_MIN_RST;
            r_zero_max   <= ZERO_MAX_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.index)
                REG_HEADER_MIN: r_header_min <= i_cfg.payload.data;
                REG_HEADER_MAX: r_header_max <= i_cfg.payload.data;
                REG_ZERO_MIN:   r_zero_min   <= i_cfg.payload.data;
                REG_ZERO_MAX:   r_zero_max   <= i_cfg.payload.data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_word <= i_in.payload;
        end
    end

    // Pulse classification and the shifted data byte.
    assign header_ok  = (r_s1_word.pulse_us >= r_header_min) &&
                        (r_s1_word.pulse_us <= r_header_max);
    assign zero_bit   = (r_s1_word.pulse_us > r_zero_min) &&
                        (r_s1_word.pulse_us < r_zero_max);
    assign count_inc  = r_bit_count + 1'b1;
    assign shifted    = {!zero_bit, r_shift_byte[CODE_W-1:1]};
    assign frame_done = (r_s1_word.command == CMD_PULSE) &&
                        (r_phase == PH_DAT_HIGH) &&
                        (r_s1_word.pulse_level == LEVEL_HIGH) &&
                        (count_inc >= FRAME_BITS);
    assign code_sum_total = r_code_sum + shifted;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (r_s1_word.command == CMD_PULSE) begin
            case (r_phase)
                PH_HDR_LOW: begin
                    if (r_s1_word.pulse_level == LEVEL_LOW && header_ok) begin
                        n_phase = PH_HDR_HIGH;
                    end
                end
                PH_HDR_HIGH: begin
                    if (r_s1_word.pulse_level == LEVEL_HIGH && header_ok) begin
                        n_phase = PH_DAT_LOW;
                    end else begin
                        n_phase = PH_HDR_LOW;
                    end
                end
                PH_DAT_LOW: begin
                    n_phase = (r_s1_word.pulse_level == LEVEL_LOW) ? PH_DAT_HIGH
                                                                   : PH_HDR_LOW;
                end
                PH_DAT_HIGH: begin
                    if (r_s1_word.pulse_level != LEVEL_HIGH || frame_done) begin
                        n_phase = PH_HDR_LOW;
                    end else begin
                        n_phase = PH_DAT_LOW;
                    end
                end
                default: n_phase = PH_HDR_LOW;
            endcase
        end
    end

    // Data path, code actions and the result word.
    always_comb begin
        n_bit_count  = r_bit_count;
        n_shift_byte = r_shift_byte;
        n_code_sum   = r_code_sum;
        n_key_store  = r_key_store;
        n_stop_flag  = r_stop_flag;
        n_debug_flag = r_debug_flag;

        if (r_s1_word.command == CMD_KEY) begin
            n_key_store = r_s1_word.key_in;
        end else if (r_phase == PH_HDR_HIGH) begin
            if (r_s1_word.pulse_level == LEVEL_HIGH && header_ok) begin
                n_bit_count = '0;
            end
        end else if (r_phase == PH_DAT_HIGH &&
                     r_s1_word.pulse_level == LEVEL_HIGH) begin
            n_shift_byte = shifted;
            n_bit_count  = count_inc;
            if (count_inc == BYTE_ONE_BITS) begin
                n_code_sum = shifted;
            end
            if (frame_done) begin
                n_bit_count = '0;
                case (code_sum_total)
                    CODE_STOP:  n_stop_flag  = !r_stop_flag;
                    CODE_DEBUG: n_debug_flag = 1'b1;
                    CODE_UP:    n_key_store  = KEY_UP;
                    CODE_OK:    n_key_store  = KEY_OK;
                    CODE_LEFT:  n_key_store  = KEY_LEFT;
                    CODE_RIGHT: n_key_store  = KEY_RIGHT;
                    CODE_DOWN:  n_key_store  = KEY_DOWN;
                    default: begin
                    end
                endcase
            end
        end

        n_out_word.key_value  = n_key_store;
        n_out_word.stop_out   = n_stop_flag;
        n_out_word.debug_out  = n_debug_flag;
        n_out_word.code_valid = frame_done;
        n_out_word.frame_code = frame_done ? code_sum_total : '0;
    end

    // Decoder state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HDR_LOW;
            r_bit_count  <= '0;
            r_shift_byte <= '0;
            r_code_sum   <= '0;
            r_key_store  <= KEY_NONE;
            r_stop_flag  <= 1'b0;
            r_debug_flag <= 1'b0;
        end else if (s1_fire) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift_byte <= n_shift_byte;
            r_code_sum   <= n_code_sum;
            r_key_store  <= n_key_store;
            r_stop_flag  <= n_stop_flag;
            r_debug_flag <= n_debug_flag;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_word <= n_out_word;
        end
    end

    // A completed frame always sends the decoder back to wait for a header.
    a_frame_end_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && frame_done) |=> (r_phase == PH_HDR_LOW && r_bit_count == '0)
    ) else $error("frame end did not return the decoder to idle");

    // The bit counter never reaches the frame length.
    a_count_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count < FRAME_BITS
    ) else $error("bit counter out of range");

    // A key overwrite leaves the decoder phase alone.
    a_key_keeps_phase: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_word.command == CMD_KEY) |=> (r_phase == $past(r_phase))
    ) else $error("key overwrite changed the decoder phase");

    // The stop flag moves only on a completed frame carrying the stop code.
    a_stop_only_on_code: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(s1_fire && frame_done && code_sum_total == CODE_STOP) |=> $stable(r_stop_flag)
    ) else $error("stop flag changed without a stop code");

    // An empty output register never holds back the input side.
    a_ready_when_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready
    ) else $error("input stalled with an empty output register");

endmodule : ir_remote_pulse_decoder

`default_nettype wire
